// File: sv/tpc_pkg.sv
package tpc_pkg;

    // Epoch and calendar constants
    localparam logic [31:0] EPOCH_OFFSET   = 32'd2208988800;
    localparam logic [31:0] DAY_SECONDS    = 32'd86400;
    localparam logic [31:0] HOUR_SECONDS   = 32'd3600;
    localparam logic [31:0] MINUTE_SECONDS = 32'd60;
    localparam logic [31:0] WEEK_DAYS      = 32'd7;
    localparam logic [31:0] YEAR_DAYS      = 32'd365;
    localparam logic [31:0] LEAP_YEAR_DAYS = 32'd366;
    localparam logic [11:0] FIRST_YEAR     = 12'd1970;
    localparam logic [15:0] EPOCH_WEEKDAY  = 16'd4;    // 1 Jan 1970 was a Thursday
    localparam logic [11:0] SKIP_CENTURY   = 12'd2100; // only non-leap century in range
    localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;

    // Reciprocals for the constant divisions, q = (x * RECIP) >> shift,
    // exact over the whole range of each dividend
    localparam logic [25:0] DAY_RECIP    = 26'd50903317; // (seconds >> 7) / 675, shift 35
    localparam logic [25:0] HOUR_RECIP   = 26'd149131;   // 17-bit seconds of day, shift 29
    localparam logic [25:0] MINUTE_RECIP = 26'd4370;     // 12-bit seconds of hour, shift 18
    localparam logic [25:0] WEEK_RECIP   = 26'd74899;    // 16-bit day count, shift 19

    // Status from the conversion core to the handshake logic
    typedef struct packed {
        logic idle;
        logic done;
    } tpc_status_t;

    // One converted result
    typedef struct packed {
        logic [31:0] unix_seconds;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
    } tpc_result_t;

    // Gregorian leap rule over the reachable years 1970..2106:
    // 2000 is a leap year (divisible by 400), 2100 is not.
    function automatic logic is_leap(input logic [11:0] y);
        is_leap = (y[1:0] == 2'b00) && (y != SKIP_CENTURY);
    endfunction

    // Month length, month index 0 = January
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        case (mon)
            4'd1:    month_len = leap ? 5'd29 : 5'd28;
            4'd3:    month_len = 5'd30;
            4'd5:    month_len = 5'd30;
            4'd8:    month_len = 5'd30;
            4'd10:   month_len = 5'd30;
            default: month_len = 5'd31;
        endcase
    endfunction

endpackage

// File: sv/time_protocol_to_calendar.sv
// Channel | Direction | Handshake            | Payload
// s_      | in        | s_valid / s_ready    | s_seconds_since_1900
// m_      | out       | m_valid / m_ready    | m_unix_seconds .. m_day_of_year
//
// Each item passes through four reciprocal divisions, then the year and month
// walks on the shared compare-subtract unit, then done and idle.
// s_ready is high only while the conversion core is idle.
// A finished result waits in the core while the output register is full and
// m_ready is low; aresetn is synchronous, active low, and clears the control state.
module time_protocol_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_seconds_since_1900,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_unix_seconds,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second,
    output logic [2:0]  m_weekday,
    output logic [8:0]  m_day_of_year
);
    import tpc_pkg::*;

    tpc_status_t status;
    tpc_result_t core_res;
    tpc_result_t out_reg;
    logic        m_valid_reg, m_valid_next;
    logic        load;

    tpc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_valid & s_ready),
        .seconds_in (s_seconds_since_1900),
        .take       (load),
        .status     (status),
        .result     (core_res)
    );

    // Hand the result over when the output register is free or being drained
    assign s_ready = status.idle;
    assign load    = status.done && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= core_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_unix_seconds = out_reg.unix_seconds;
    assign m_year         = out_reg.year;
    assign m_month        = out_reg.month;
    assign m_day_of_month = out_reg.day_of_month;
    assign m_hour         = out_reg.hour;
    assign m_minute       = out_reg.minute;
    assign m_second       = out_reg.second;
    assign m_weekday      = out_reg.weekday;
    assign m_day_of_year  = out_reg.day_of_year;
endmodule

// File: sv/tpc_sub_unit.sv
module tpc_sub_unit (
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        ge,
    output logic [31:0] diff
);
    logic [32:0] sub;

    // Shared compare-and-subtract: keep a when it is below b
    assign sub  = {1'b0, a} - {1'b0, b};
    assign ge   = ~sub[32];
    assign diff = ge ? sub[31:0] : a;
endmodule

// File: sv/tpc_core.sv
module tpc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [31:0]          seconds_in,
    input  logic                 take,
    output tpc_pkg::tpc_status_t status,
    output tpc_pkg::tpc_result_t result
);
    import tpc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV_Q = 3'd1;
    localparam logic [2:0] ST_DIV_R = 3'd2;
    localparam logic [2:0] ST_DIV_S = 3'd3;
    localparam logic [2:0] ST_YEAR  = 3'd4;
    localparam logic [2:0] ST_MONTH = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Constant division in progress
    localparam logic [1:0] DIV_DAY  = 2'd0;
    localparam logic [1:0] DIV_HOUR = 2'd1;
    localparam logic [1:0] DIV_MIN  = 2'd2;
    localparam logic [1:0] DIV_WDAY = 2'd3;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  div_reg, div_next;
    logic [31:0] acc_reg, acc_next;
    logic [50:0] prod_reg, prod_next;
    logic [15:0] q_reg, q_next;
    logic [15:0] days_reg, days_next;
    logic [3:0]  mon_reg, mon_next;
    tpc_result_t res_reg, res_next;

    logic [31:0] unit_a, unit_b, unit_diff;
    logic        unit_ge;
    logic        leap;
    logic [24:0] mul_a;
    logic [25:0] mul_b;
    logic [50:0] mul_p;
    logic [25:0] recip;
    logic [16:0] divisor;
    logic [15:0] quot;

    tpc_sub_unit u_sub (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    assign leap = is_leap(res_reg.year);

    // Reciprocal, divisor and quotient bits for the division in progress
    always_comb begin
        recip   = DAY_RECIP;
        divisor = DAY_SECONDS[16:0];
        quot    = prod_reg[50:35];
        case (div_reg)
            DIV_HOUR: begin
                recip   = HOUR_RECIP;
                divisor = HOUR_SECONDS[16:0];
                quot    = prod_reg[44:29];
            end
            DIV_MIN: begin
                recip   = MINUTE_RECIP;
                divisor = MINUTE_SECONDS[16:0];
                quot    = prod_reg[33:18];
            end
            DIV_WDAY: begin
                recip   = WEEK_RECIP;
                divisor = WEEK_DAYS[16:0];
                quot    = prod_reg[34:19];
            end
            default: begin
                recip   = DAY_RECIP;
                divisor = DAY_SECONDS[16:0];
                quot    = prod_reg[50:35];
            end
        endcase
    end

    // Shared multiplier: dividend times reciprocal, then quotient times divisor
    always_comb begin
        if (state_reg == ST_DIV_R) begin
            mul_a = {9'd0, quot};
            mul_b = {9'd0, divisor};
        end else begin
            mul_a = (div_reg == DIV_DAY) ? acc_reg[31:7] : acc_reg[24:0];
            mul_b = recip;
        end
    end

    assign mul_p = {26'd0, mul_a} * {25'd0, mul_b};

    // Operand selection for the shared compare-subtract unit
    always_comb begin
        unit_a = acc_reg;
        case (state_reg)
            ST_YEAR:  unit_b = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
            ST_MONTH: unit_b = {27'd0, month_len(leap, mon_reg)};
            default:  unit_b = prod_reg[31:0];
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        div_next   = div_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        q_next     = q_reg;
        days_next  = days_reg;
        mon_next   = mon_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    res_next.unix_seconds = seconds_in - EPOCH_OFFSET;
                    acc_next   = seconds_in - EPOCH_OFFSET;
                    div_next   = DIV_DAY;
                    state_next = ST_DIV_Q;
                end
            end
            ST_DIV_Q: begin
                prod_next  = mul_p;
                state_next = ST_DIV_R;
            end
            ST_DIV_R: begin
                // quotient from the high product bits
                q_next     = quot;
                prod_next  = mul_p;
                state_next = ST_DIV_S;
            end
            ST_DIV_S: begin
                // remainder = dividend - quotient * divisor
                div_next   = div_reg + 2'd1;
                state_next = ST_DIV_Q;
                case (div_reg)
                    DIV_DAY: begin
                        days_next = q_reg;
                        acc_next  = unit_diff;
                    end
                    DIV_HOUR: begin
                        res_next.hour = q_reg[4:0];
                        acc_next      = unit_diff;
                    end
                    DIV_MIN: begin
                        res_next.minute = q_reg[5:0];
                        res_next.second = unit_diff[5:0];
                        acc_next        = {16'd0, days_reg + EPOCH_WEEKDAY};
                    end
                    DIV_WDAY: begin
                        res_next.weekday = unit_diff[2:0];
                        res_next.year    = FIRST_YEAR;
                        acc_next         = {16'd0, days_reg};
                        state_next       = ST_YEAR;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_YEAR: begin
                // drop whole years while the day count covers one
                if (unit_ge) begin
                    acc_next      = unit_diff;
                    res_next.year = res_reg.year + 12'd1;
                end else begin
                    res_next.day_of_year = acc_reg[8:0];
                    mon_next   = '0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                // drop whole months, December takes the rest
                if (unit_ge && mon_reg != LAST_MONTH_IDX) begin
                    acc_next = unit_diff;
                    mon_next = mon_reg + 4'd1;
                end else begin
                    res_next.month        = mon_reg + 4'd1;
                    res_next.day_of_month = acc_reg[4:0] + 5'd1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        div_reg  <= div_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        days_reg <= days_next;
        mon_reg  <= mon_next;
        res_reg  <= res_next;
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign result      = res_reg;
endmodule

// File: tb/time_protocol_to_calendar_tb.sv
`timescale 1ns / 100ps

module time_protocol_to_calendar_tb;
    import tpc_pkg::*;

    localparam int CLOCK_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int REPORT_LIMIT  = 10;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_seconds_since_1900;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_unix_seconds;
    logic [11:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day_of_month;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;
    logic [2:0]  m_weekday;
    logic [8:0]  m_day_of_year;

    // Dates still owed by the block, oldest first
    tpc_result_t pending_dates[$];
    tpc_result_t want_date;
    tpc_result_t got_date;

    int send_idle_pct;
    int recv_idle_pct;
    int answers_sent;
    int directed_sent;
    int dates_checked;
    int date_mismatches;
    int cycle_count;

    time_protocol_to_calendar dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_seconds_since_1900 (s_seconds_since_1900),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_unix_seconds       (m_unix_seconds),
        .m_year               (m_year),
        .m_month              (m_month),
        .m_day_of_month       (m_day_of_month),
        .m_hour               (m_hour),
        .m_minute             (m_minute),
        .m_second             (m_second),
        .m_weekday            (m_weekday),
        .m_day_of_year        (m_day_of_year)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Full Gregorian rule, centuries included
    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned year_length(input int unsigned yr);
        return leap_year(yr) ? LEAP_YEAR_DAYS : YEAR_DAYS;
    endfunction

    // mon counts from 1 = January
    function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mon);
        case (mon)
            2:             return leap_year(yr) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Calendar fields that a given Time Protocol answer should produce
    function automatic tpc_result_t calendar_of(input logic [31:0] answer);
        tpc_result_t r;
        int unsigned unix_s;
        int unsigned tod;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        unix_s = answer - EPOCH_OFFSET;
        tod    = unix_s % DAY_SECONDS;
        days   = unix_s / DAY_SECONDS;
        r.unix_seconds = unix_s;
        r.weekday      = 3'((days + EPOCH_WEEKDAY) % WEEK_DAYS);
        yr = FIRST_YEAR;
        while (days >= year_length(yr)) begin
            days -= year_length(yr);
            yr++;
        end
        r.year        = 12'(yr);
        r.day_of_year = 9'(days);
        mon = 1;
        while (mon < 12 && days >= days_in_month(yr, mon)) begin
            days -= days_in_month(yr, mon);
            mon++;
        end
        r.month        = 4'(mon);
        r.day_of_month = 5'(days + 1);
        r.hour         = 5'(tod / HOUR_SECONDS);
        r.minute       = 6'((tod % HOUR_SECONDS) / MINUTE_SECONDS);
        r.second       = 6'(tod % MINUTE_SECONDS);
        return r;
    endfunction

    // Answer value for a given year, day of year and second of day (year <= 2105)
    function automatic logic [31:0] answer_at(input int unsigned yr, input int unsigned yday,
                                              input int unsigned tod);
        int unsigned days;
        days = 0;
        for (int unsigned y = FIRST_YEAR; y < yr; y++) days += year_length(y);
        return EPOCH_OFFSET + (days + yday) * DAY_SECONDS + tod;
    endfunction

    // One transfer on the input channel; the valid stays up until the next call
    task automatic send_answer(input logic [31:0] secs);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid              = 1'b1;
        s_seconds_since_1900 = secs;
        do @(posedge aclk); while (!s_ready);
        pending_dates.push_back(calendar_of(secs));
        answers_sent++;
    endtask

    task automatic note_mismatch(input string what);
        date_mismatches++;
        if (date_mismatches <= REPORT_LIMIT) $display("cycle %0d: %s", cycle_count, what);
    endtask

    // Receiver backpressure
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_date = '{m_unix_seconds, m_year, m_month, m_day_of_month, m_hour,
                         m_minute, m_second, m_weekday, m_day_of_year};
            if (pending_dates.size() == 0) begin
                note_mismatch($sformatf("result transfer with nothing pending: %p", got_date));
            end else begin
                want_date = pending_dates.pop_front();
                dates_checked++;
                if (got_date.unix_seconds !== want_date.unix_seconds ||
                    got_date.year !== want_date.year ||
                    got_date.month !== want_date.month ||
                    got_date.day_of_month !== want_date.day_of_month ||
                    got_date.hour !== want_date.hour ||
                    got_date.minute !== want_date.minute ||
                    got_date.second !== want_date.second ||
                    got_date.weekday !== want_date.weekday ||
                    got_date.day_of_year !== want_date.day_of_year) begin
                    note_mismatch($sformatf("date mismatch\n  expected %p\n  actual   %p",
                                            want_date, got_date));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CLOCK_LIMIT) begin
            $display("cycle limit of %0d reached, %0d dates still pending",
                     CLOCK_LIMIT, pending_dates.size());
            $display("time_protocol_to_calendar_tb NOT OK");
            $finish;
        end
    end

    // Field extremes and the wrap below the 1970 offset
    task automatic test_field_extremes;
        send_answer(32'h0000_0000);
        send_answer(32'hFFFF_FFFF);
        send_answer(EPOCH_OFFSET);
        send_answer(EPOCH_OFFSET - 32'd1);
        send_answer(EPOCH_OFFSET + 32'd1);
        send_answer(32'h8000_0000);
        send_answer(32'h7FFF_FFFF);
        send_answer(32'h5555_5555);
        send_answer(32'hAAAA_AAAA);
    endtask

    // Leap days, the 2100 century exception, ends of day and year
    task automatic test_leap_and_century;
        send_answer(answer_at(2000, 59, 0));
        send_answer(answer_at(2000, 60, 0));
        send_answer(answer_at(2100, 58, 86399));
        send_answer(answer_at(2100, 59, 0));
        send_answer(answer_at(2100, 364, 86399));
        send_answer(answer_at(2096, 365, 43210));
        send_answer(answer_at(1970, 364, 86399));
        send_answer(answer_at(2038, 18, 11647));
        send_answer(answer_at(2104, 59, 3600));
    endtask

    // Random answers: mostly uniform, the rest near day and year edges or at random times
    task automatic test_random_answers(input int count, input int sender_pct,
                                       input int receiver_pct);
        int unsigned yr;
        logic [31:0] secs;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (count) begin
            yr = $urandom_range(2105, FIRST_YEAR);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: secs = $urandom;
                6, 7: secs = answer_at(yr, $urandom_range(year_length(yr) - 1), 0)
                             + 32'($urandom_range(2)) - 32'd1;
                8: secs = answer_at(yr, year_length(yr) - 1, 86399)
                          + 32'($urandom_range(1));
                default: secs = answer_at(yr, $urandom_range(year_length(yr) - 1),
                                          $urandom_range(86399));
            endcase
            send_answer(secs);
        end
    endtask

    initial begin
        aresetn              = 1'b0;
        s_valid              = 1'b0;
        s_seconds_since_1900 = '0;
        m_ready              = 1'b0;
        cycle_count          = 0;
        send_idle_pct        = 38;
        recv_idle_pct        = 50;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_field_extremes();
        test_leap_and_century();
        directed_sent = answers_sent;
        test_random_answers(300, 38, 50);
        test_random_answers(300, 50, 38);
        test_random_answers(300, 0, 0);

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d time answers sent (%0d directed), %0d dates checked, %0d mismatches",
                 answers_sent, directed_sent, dates_checked, date_mismatches);
        $display("covered pre-1970 wrap, 2000 and 2100 leap rules, day and year edges");
        if (date_mismatches == 0 && pending_dates.size() == 0) begin
            $display("time_protocol_to_calendar_tb OK");
        end else begin
            $display("time_protocol_to_calendar_tb NOT OK");
        end
        $finish;
    end

endmodule
